/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// ASSERT_CLK takes a label, a clock, an active-low reset, a property and a message; ASSERT_CLK_ALWAYS takes no reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising edge, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked at each rising edge, during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/fss_pkg.sv */
// Package for the fuzzy subsequence scorer: sizes, command codes, scoring constants,
// the candidate walk state type and the case-folding function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    localparam int QUERY_DEPTH = 32;
    localparam int POS_W       = 16;
    localparam int SCORE_W     = 18;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int IDX_W       = $clog2(QUERY_DEPTH + 1);
    localparam int STORE_AW    = $clog2(QUERY_DEPTH);
    localparam int EXT_W       = ((SCORE_W > POS_W + 1) ? SCORE_W : POS_W + 1) + 2;

    localparam int BONUS_BOUNDARY = 16;
    localparam int BONUS_CONTIG   = 8;
    localparam int BONUS_CASE     = 1;
    localparam int GAP_OPEN       = 3;

    localparam logic signed [EXT_W-1:0] SCORE_MAX_EXT =
        EXT_W'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] SCORE_MIN_EXT =
        EXT_W'(-(64'sd1 <<< (SCORE_W - 1)));

    localparam logic [CFG_W-1:0] FLOOR_RESET = CFG_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_FLOOR  = CFG_IDX_W'(1);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CAND   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]          qidx;
        logic [POS_W-1:0]          pos;
        logic [POS_W-1:0]          last;
        logic                      seen;
        logic [7:0]                prev;
        logic signed [SCORE_W-1:0] run;
        logic signed [SCORE_W-1:0] best;
        logic                      best_valid;
    } t_cand;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fss_step.sv */
// Next state of the candidate walk for one candidate byte: match test, bonuses,
// gap penalty, saturation and best-score tracking. Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fss_step (
    input  fss_pkg::t_cand                i_cur,
    input  logic [7:0]                    i_byte,
    input  logic [7:0]                    i_qbyte,
    input  logic [fss_pkg::IDX_W-1:0]     i_qlen,
    input  logic [fss_pkg::CFG_W-1:0]     i_floor,
    output fss_pkg::t_cand                o_next
);

    localparam int EW = fss_pkg::EXT_W;
    localparam int PW = fss_pkg::POS_W;

    logic                      hit;
    logic                      boundary;
    logic                      gap;
    logic                      contig;
    logic [PW:0]               pos_x;
    logic [PW:0]               last_p1;
    logic [PW:0]               pen;
    logic signed [EW-1:0]      sum;
    logic signed [EW-1:0]      sat;
    logic signed [fss_pkg::SCORE_W-1:0] run_new;
    logic [fss_pkg::IDX_W-1:0] qidx_new;

    always_comb begin
        hit = (i_cur.qidx < i_qlen) && (fss_pkg::fold(i_byte) == fss_pkg::fold(i_qbyte));

        boundary = (i_cur.pos == '0)
                || (i_cur.prev == fss_pkg::CH_UNDERSCORE)
                || (i_cur.prev == fss_pkg::CH_DASH)
                || (i_cur.prev == fss_pkg::CH_DOT)
                || (i_cur.prev == fss_pkg::CH_SLASH)
                || (i_cur.prev == fss_pkg::CH_COLON)
                || (i_cur.prev == fss_pkg::CH_SPACE)
                || (fss_pkg::is_lower(i_cur.prev) && fss_pkg::is_upper(i_byte));

        pos_x   = {1'b0, i_cur.pos};
        last_p1 = {1'b0, i_cur.last} + (PW+1)'(1);
        gap     = i_cur.seen && (pos_x > last_p1);
        contig  = i_cur.seen && (pos_x == last_p1);
        // The open cost plus one per extra byte reduces to pos - last + 1.
        pen     = pos_x - {1'b0, i_cur.last} + (PW+1)'(fss_pkg::GAP_OPEN - 2);

        sum = EW'(i_cur.run);
        if (gap) begin
            sum = sum - EW'(pen);
        end
        if (boundary) begin
            sum = sum + EW'(fss_pkg::BONUS_BOUNDARY);
        end
        if (contig) begin
            sum = sum + EW'(fss_pkg::BONUS_CONTIG);
        end
        if (i_byte == i_qbyte) begin
            sum = sum + EW'(fss_pkg::BONUS_CASE);
        end

        if (sum < fss_pkg::SCORE_MIN_EXT) begin
            sat = fss_pkg::SCORE_MIN_EXT;
        end else if (sum > fss_pkg::SCORE_MAX_EXT) begin
            sat = fss_pkg::SCORE_MAX_EXT;
        end else begin
            sat = sum;
        end
        run_new  = sat[fss_pkg::SCORE_W-1:0];
        qidx_new = i_cur.qidx + fss_pkg::IDX_W'(1);

        o_next      = i_cur;
        o_next.prev = i_byte;
        if (i_cur.pos != '1) begin
            o_next.pos = i_cur.pos + PW'(1);
        end
        if (hit) begin
            o_next.run  = run_new;
            o_next.last = i_cur.pos;
            o_next.seen = 1'b1;
            o_next.qidx = qidx_new;
            if ((32'(qidx_new) >= 32'(i_floor))
                    && (!i_cur.best_valid || (run_new > i_cur.best))) begin
                o_next.best       = run_new;
                o_next.best_valid = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fuzzy_subsequence_scorer.sv */
// Top level of the fuzzy subsequence scorer: query store, candidate walk state,
// configuration registers and the result register. Depends on fss_pkg and fss_step.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_command, i_data_byte
//   result    out        o_valid / i_stall    o_matched, o_score, o_consumed
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Every accepted word is applied to the walk state at the edge that accepts it.
// An end word loads the result register at that edge; the result shows the next cycle.
// Synchronous active-low reset empties the query and the walk, restores the config registers and clears o_valid.
// The input stalls only while a result waits and the result side stalls.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_scorer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_matched,
    output logic signed [fss_pkg::SCORE_W-1:0] o_score,
    output logic [fss_pkg::CFG_W-1:0]          o_consumed,
    input  logic                               i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fss_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [7:0]                      r_qstore [fss_pkg::QUERY_DEPTH];
    logic [fss_pkg::IDX_W-1:0]       r_qlen;
    logic [fss_pkg::IDX_W-1:0]       n_qlen;
    fss_pkg::t_cand                  r_cand;
    fss_pkg::t_cand                  n_cand;
    fss_pkg::t_cand                  step_next;
    logic                            r_partial;
    logic [fss_pkg::CFG_W-1:0]       r_floor;
    logic                            r_out_valid;
    logic                            r_matched;
    logic signed [fss_pkg::SCORE_W-1:0] r_score;
    logic [fss_pkg::CFG_W-1:0]       r_consumed;
    logic                            n_ok;
    logic signed [fss_pkg::SCORE_W-1:0] n_score;
    logic                            in_acc;
    logic                            out_acc;
    logic                            store_we;
    logic [7:0]                      qbyte;

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign qbyte   = r_qstore[r_cand.qidx[fss_pkg::STORE_AW-1:0]];

    fss_step u_step (
        .i_cur   (r_cand),
        .i_byte  (i_data_byte),
        .i_qbyte (qbyte),
        .i_qlen  (r_qlen),
        .i_floor (r_floor),
        .o_next  (step_next)
    );

    always_comb begin
        n_qlen   = r_qlen;
        n_cand   = r_cand;
        store_we = 1'b0;
        if (in_acc) begin
            case (fss_pkg::t_cmd'(i_command))
                fss_pkg::CMD_CLEAR: begin
                    n_qlen = '0;
                    n_cand = '0;
                end
                fss_pkg::CMD_APPEND: begin
                    if (32'(r_qlen) < fss_pkg::QUERY_DEPTH) begin
                        store_we = 1'b1;
                        n_qlen   = r_qlen + fss_pkg::IDX_W'(1);
                    end
                    n_cand = '0;
                end
                fss_pkg::CMD_CAND: begin
                    n_cand = step_next;
                end
                fss_pkg::CMD_END: begin
                    n_cand = '0;
                end
                default: begin
                    n_cand = r_cand;
                end
            endcase
        end

        if (r_partial) begin
            n_ok    = r_cand.best_valid && (32'(r_qlen) >= 32'(r_floor));
            n_score = r_cand.best;
        end else if (r_qlen == '0) begin
            n_ok    = 1'b1;
            n_score = '0;
        end else begin
            n_ok    = (r_cand.qidx == r_qlen);
            n_score = r_cand.run;
        end
        if (!n_ok) begin
            n_score = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_qstore[r_qlen[fss_pkg::STORE_AW-1:0]] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen      <= '0;
            r_cand      <= '0;
            r_partial   <= 1'b0;
            r_floor     <= fss_pkg::FLOOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_qlen <= n_qlen;
            r_cand <= n_cand;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fss_pkg::CFG_PARTIAL_MODE: r_partial <= i_cfg_data[0];
                    fss_pkg::CFG_MATCH_FLOOR:  r_floor   <= i_cfg_data;
                    default:                   r_floor   <= r_floor;
                endcase
            end
            if (in_acc && (fss_pkg::t_cmd'(i_command) == fss_pkg::CMD_END)) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (fss_pkg::t_cmd'(i_command) == fss_pkg::CMD_END)) begin
            r_matched  <= n_ok;
            r_score    <= n_score;
            r_consumed <= fss_pkg::CFG_W'(r_cand.qidx);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_score    = r_score;
    assign o_consumed = r_consumed;

endmodule

`default_nettype wire

/* rtl/core/fss_checker.sv */
// Port-level checker for the fuzzy subsequence scorer and its bind to the top level.
// Depends on fss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fss_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic [1:0]                         i_command,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic                               o_matched,
    input  logic signed [fss_pkg::SCORE_W-1:0] o_score,
    input  logic [fss_pkg::CFG_W-1:0]          o_consumed
);

    logic end_acc;

    assign end_acc = i_valid && !o_stall && (i_command == fss_pkg::CMD_END);

    // A waiting result word stays until it is taken.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped")

    // A result word appears only after an end word was accepted.
    `ASSERT_CLK(a_out_cause, i_clk, i_rst_n, $rose(o_valid) |-> $past(end_acc), "no end word")

    // An unmatched candidate reports a zero score.
    `ASSERT_CLK(a_zero_score, i_clk, i_rst_n, o_valid && !o_matched |-> o_score == '0, "bad score")

    // Never more query bytes consumed than the store holds.
    `ASSERT_CLK(a_consumed_range, i_clk, i_rst_n,
        o_valid |-> 32'(o_consumed) <= fss_pkg::QUERY_DEPTH, "consumed count too large")

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_command  (i_command),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_matched  (o_matched),
    .o_score    (o_score),
    .o_consumed (o_consumed)
);

`default_nettype wire
